// File: design/salc_pkg.sv
// ============================================================================
// salc_pkg
// Shared constants, types and codes for the set-associative LRU cache model.
// ============================================================================
package salc_pkg;

  localparam int MAX_SET_BITS   = 6;
  localparam int WAYS           = 8;
  localparam int ADDR_BITS      = 48;
  localparam int MAX_BLOCK_BITS = 16;

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_MAX   = WAYS - 1;
  localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(WAYS + 1);
  localparam int CNT_W     = 32;
  localparam int SHIFT_W   = 6;

  // access kinds
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS_USED  = 2'd2;

  // one set of the tag store
  typedef struct packed {
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0][ADDR_BITS-1:0] tag;
    logic [WAYS-1:0][AGE_W-1:0]     age;
  } row_t;

  // per-access outcome
  typedef struct packed {
    logic [1:0] hits;
    logic       missed;
    logic       evicted;
  } res_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

// File: design/salc_set_update.sv
// ============================================================================
// salc_set_update
// Lookup, victim choice and LRU rank update for one set row.
// ============================================================================
module salc_set_update
  import salc_pkg::*;
(
  input  row_t                 row_i,
  input  logic [ADDR_BITS-1:0] tag_i,
  input  logic [WAY_CNT_W-1:0] ways_i,
  input  logic                 modify_i,
  output row_t                 row_o,
  output res_t                 res_o
);

  logic [WAYS-1:0]      in_use;
  logic [WAYS-1:0]      match;
  logic                 hit;
  logic                 has_idle;
  logic [WAY_IDX_W-1:0] hit_way;
  logic [WAY_IDX_W-1:0] idle_way;
  logic [WAY_IDX_W-1:0] victim;
  logic [AGE_W-1:0]     victim_age;
  logic [WAY_IDX_W-1:0] sel_way;
  logic                 was_valid;
  logic [AGE_W-1:0]     old_age;

  always_comb begin
    hit_way    = '0;
    idle_way   = '0;
    victim     = '0;
    victim_age = '0;
    has_idle   = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      in_use[i] = WAY_CNT_W'(i) < ways_i;
      match[i]  = in_use[i] && row_i.valid[i] && (row_i.tag[i] == tag_i);
    end
    hit = |match;
    // lowest matching way wins
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WAY_IDX_W'(i);
      end
    end
    // highest free way, and lowest way of greatest age
    for (int i = 0; i < WAYS; i++) begin
      if (in_use[i]) begin
        if (!row_i.valid[i]) begin
          has_idle = 1'b1;
          idle_way = WAY_IDX_W'(i);
        end else if (i == 0 || row_i.age[i] > victim_age) begin
          victim     = WAY_IDX_W'(i);
          victim_age = row_i.age[i];
        end
      end
    end
    sel_way   = hit ? hit_way : (has_idle ? idle_way : victim);
    was_valid = hit || !has_idle;
    old_age   = row_i.age[sel_way];

    row_o = row_i;
    for (int i = 0; i < WAYS; i++) begin
      if (in_use[i] && row_i.valid[i] && (WAY_IDX_W'(i) != sel_way) &&
          (!was_valid || row_i.age[i] < old_age) &&
          (row_i.age[i] < AGE_W'(AGE_MAX))) begin
        row_o.age[i] = row_i.age[i] + AGE_W'(1);
      end
    end
    row_o.age[sel_way] = '0;
    if (!hit) begin
      row_o.tag[sel_way]   = tag_i;
      row_o.valid[sel_way] = 1'b1;
    end

    res_o.hits    = {hit & modify_i, hit ^ modify_i};
    res_o.missed  = !hit;
    res_o.evicted = !hit && !has_idle;
  end

endmodule

// File: design/set_assoc_lru_cache_sim.sv
// ============================================================================
// set_assoc_lru_cache_sim
// Set-associative cache simulator with true LRU and saturating counters.
// ============================================================================
// Each access word (mode on in_tuser, byte address on in_tdata) is looked up
// in a 64-set by 8-way tag store held in one synchronous memory, one row per
// set. An access first reads the set row into a register; the lookup state
// then compares tags, picks the hit, free or victim way, re-ranks the ages
// and writes the row back while the result is loaded into the output
// register. The next access is taken right after the write back, so accesses
// never overlap on the memory, and the block takes no new access before the
// read-modify-write of the last set row is done; if the previous result has
// not been taken, the write back holds until the output register frees.
// A flag per set marks rows never written, which read as empty, so reset
// needs no clearing pass and the block is ready in the first cycle after it.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module set_assoc_lru_cache_sim
  import salc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [4:0]   cfg_wdata,
  // access stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // [47:0] address
  input  logic [1:0]   in_tuser,   // [1:0] mode
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] hits_added, [2] missed, [3] evicted, [35:4] total_hits,
  // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
  output logic [103:0] out_tdata
);

  // configuration registers
  logic [2:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd4;
      block_bits_r <= 5'd4;
      ways_used_r  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[2:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata;
        CFG_WAYS_USED:  ways_used_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  logic [2:0]           s_eff;
  logic [4:0]           b_eff;
  logic [3:0]           ways_clamp;
  logic [WAY_CNT_W-1:0] ways_eff;

  always_comb begin
    s_eff = (set_bits_r > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_r;
    b_eff = (block_bits_r > 5'(MAX_BLOCK_BITS)) ? 5'(MAX_BLOCK_BITS) : block_bits_r;
    if (ways_used_r == 4'd0) begin
      ways_clamp = 4'd1;
    end else if (ways_used_r > 4'(WAYS)) begin
      ways_clamp = 4'(WAYS);
    end else begin
      ways_clamp = ways_used_r;
    end
    ways_eff = WAY_CNT_W'(ways_clamp);
  end

  // split the address into set index and tag
  logic [ADDR_BITS-1:0] addr_shift;
  logic [SHIFT_W-1:0]   tag_shift;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     set_in;
  logic [ADDR_BITS-1:0] tag_in;

  always_comb begin
    addr_shift = in_tdata[ADDR_BITS-1:0] >> b_eff;
    set_mask   = ~({SET_W{1'b1}} << s_eff);
    set_in     = addr_shift[SET_W-1:0] & set_mask;
    tag_shift  = SHIFT_W'(b_eff) + SHIFT_W'(s_eff);
    tag_in     = in_tdata[ADDR_BITS-1:0] >> tag_shift;
  end

  // control
  state_t state_r, state_nxt;
  logic   in_fire;
  logic   commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // write back only when the result can land
        if (!out_tvalid || out_tready) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_fire = in_tvalid && in_tready;

  // hold the access while its set row is read
  logic [SET_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic                 modify_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r    <= set_in;
      tag_r    <= tag_in;
      modify_r <= (in_tuser == MODE_MODIFY);
    end
  end

  // tag store: one row per set, plus a written flag per row
  row_t                tag_mem [NUM_SETS];
  row_t                rd_row_r;
  logic                rd_ok_r;
  logic [NUM_SETS-1:0] row_ok_r;
  row_t                cur_row;
  row_t                new_row;
  res_t                upd_res;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_row_r <= tag_mem[set_in];
    end
    if (commit) begin
      tag_mem[set_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
      rd_ok_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_ok_r <= row_ok_r[set_in];
      end
      if (commit) begin
        row_ok_r[set_r] <= 1'b1;
      end
    end
  end

  // a row never written reads as empty
  assign cur_row = rd_ok_r ? rd_row_r : '0;

  salc_set_update u_upd (
    .row_i    (cur_row),
    .tag_i    (tag_r),
    .ways_i   (ways_eff),
    .modify_i (modify_r),
    .row_o    (new_row),
    .res_o    (upd_res)
  );

  // running totals, saturating
  logic [CNT_W-1:0] hit_total_r, miss_total_r, evict_total_r;
  logic [CNT_W:0]   hit_sum, miss_sum, evict_sum;

  always_comb begin
    hit_sum   = {1'b0, hit_total_r} + (CNT_W+1)'(upd_res.hits);
    miss_sum  = {1'b0, miss_total_r} + (CNT_W+1)'(upd_res.missed);
    evict_sum = {1'b0, evict_total_r} + (CNT_W+1)'(upd_res.evicted);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
    end else if (commit) begin
      hit_total_r   <= hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
      miss_total_r  <= miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
      evict_total_r <= evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
    end
  end

  // output register; the totals change only on commit, so they hold too
  logic out_valid_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= upd_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, evict_total_r, miss_total_r, hit_total_r,
                       res_r.evicted, res_r.missed, res_r.hits};

  // checks
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_tready))
    else $error("write back while result register is full");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready && state_r == ST_LOOK)
    else $error("access taken while a lookup is in flight");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!res_r.evicted || res_r.missed) && res_r.hits != 2'd3))
    else $error("inconsistent access result");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && upd_res.missed && miss_total_r != '1) |=>
      miss_total_r == $past(miss_total_r) + CNT_W'(1))
    else $error("miss total did not advance");

  a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> hit_total_r == $past(hit_total_r))
    else $error("hit total moved without an access");

endmodule

// File: bench/tb_set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// Testbench for set_assoc_lru_cache_sim
// Streams load, store and modify accesses into the cache and checks every
// result word against a predictor. The predictor keeps its own tag store,
// LRU ranks and running totals. The run covers several cache geometries,
// way counts that shrink and grow again, and random stalls on both streams.
// ----------------------------------------------------------------------------
import salc_pkg::*;

typedef struct packed {
  logic [1:0]       hits;
  logic             missed;
  logic             evicted;
  logic [CNT_W-1:0] hit_sum;
  logic [CNT_W-1:0] miss_sum;
  logic [CNT_W-1:0] evict_sum;
} access_outcome_t;

class cache_scoreboard;
  logic                 line_live [NUM_SETS*WAYS];
  logic [ADDR_BITS-1:0] line_key  [NUM_SETS*WAYS];
  logic [AGE_W-1:0]     line_rank [NUM_SETS*WAYS];
  logic [2:0]           set_bits_r;
  logic [4:0]           block_bits_r;
  logic [3:0]           ways_used_r;
  logic [CNT_W-1:0]     hit_sum;
  logic [CNT_W-1:0]     miss_sum;
  logic [CNT_W-1:0]     evict_sum;
  access_outcome_t      awaited_outcomes[$];
  int                   checked;
  int                   mismatches;

  function new();
    foreach (line_live[i]) begin
      line_live[i] = 1'b0;
      line_key[i]  = '0;
      line_rank[i] = '0;
    end
    set_bits_r   = 3'd4;
    block_bits_r = 5'd4;
    ways_used_r  = 4'd1;
    hit_sum      = '0;
    miss_sum     = '0;
    evict_sum    = '0;
    checked      = 0;
    mismatches   = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [4:0] val);
    case (idx)
      CFG_SET_BITS:   set_bits_r   = val[2:0];
      CFG_BLOCK_BITS: block_bits_r = val;
      CFG_WAYS_USED:  ways_used_r  = val[3:0];
      default: ;
    endcase
  endfunction

  // Move way w to the front; only live lines that were more recent move back
  // when w already held a line.
  function void promote(int base, int ways, int w, bit was_live);
    logic [AGE_W-1:0] old_rank;
    int i;
    old_rank = line_rank[base + w];
    for (i = 0; i < ways; i++) begin
      if (i != w && line_live[base + i] &&
          (!was_live || line_rank[base + i] < old_rank) &&
          line_rank[base + i] < AGE_MAX)
        line_rank[base + i]++;
    end
    line_rank[base + w] = '0;
  endfunction

  function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] sum, logic [CNT_W-1:0] inc);
    return (sum > '1 - inc) ? '1 : sum + inc;
  endfunction

  function void note_access(logic [1:0] mode, logic [ADDR_BITS-1:0] addr);
    int s, b, ways, base, hit_way, free_way, victim, i;
    logic [AGE_W-1:0]     victim_rank;
    logic [ADDR_BITS-1:0] set_mask, key;
    access_outcome_t      want;
    bit                   modify;
    s        = (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_r;
    b        = (block_bits_r > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : block_bits_r;
    ways     = (ways_used_r == 0) ? 1 : ((ways_used_r > WAYS) ? WAYS : ways_used_r);
    modify   = (mode == MODE_MODIFY);
    set_mask = ~({ADDR_BITS{1'b1}} << s);
    key      = addr >> (b + s);
    base     = int'((addr >> b) & set_mask) * WAYS;
    hit_way  = -1;
    free_way = -1;
    victim   = 0;
    victim_rank = '0;
    for (i = 0; i < ways; i++) begin
      if (line_live[base + i]) begin
        if (hit_way < 0 && line_key[base + i] == key) hit_way = i;
        if (i == 0 || line_rank[base + i] > victim_rank) begin
          victim      = i;
          victim_rank = line_rank[base + i];
        end
      end else begin
        free_way = i;
      end
    end
    want = '0;
    if (hit_way >= 0) begin
      want.hits = modify ? 2'd2 : 2'd1;
      promote(base, ways, hit_way, 1'b1);
    end else begin
      want.missed = 1'b1;
      want.hits   = modify ? 2'd1 : 2'd0;
      if (free_way >= 0) begin
        promote(base, ways, free_way, 1'b0);
        line_live[base + free_way] = 1'b1;
        line_key[base + free_way]  = key;
      end else begin
        want.evicted = 1'b1;
        promote(base, ways, victim, 1'b1);
        line_key[base + victim] = key;
      end
    end
    hit_sum   = bump(hit_sum, CNT_W'(want.hits));
    miss_sum  = bump(miss_sum, CNT_W'(want.missed));
    evict_sum = bump(evict_sum, CNT_W'(want.evicted));
    want.hit_sum   = hit_sum;
    want.miss_sum  = miss_sum;
    want.evict_sum = evict_sum;
    awaited_outcomes.push_back(want);
  endfunction

  function void check_outcome(logic [103:0] word);
    access_outcome_t want;
    if (awaited_outcomes.size() == 0) begin
      if (mismatches < 10)
        $display("ERROR %0t: result word with no access outstanding: %h", $time, word);
      mismatches++;
      return;
    end
    want = awaited_outcomes.pop_front();
    checked++;
    if (word[1:0] !== want.hits || word[2] !== want.missed || word[3] !== want.evicted ||
        word[35:4] !== want.hit_sum || word[67:36] !== want.miss_sum ||
        word[99:68] !== want.evict_sum || word[103:100] !== 4'd0) begin
      if (mismatches < 10) begin
        $write("ERROR %0t: access %0d expected hits %0d miss %0d evict %0d totals %0d/%0d/%0d, ",
               $time, checked, want.hits, want.missed, want.evicted,
               want.hit_sum, want.miss_sum, want.evict_sum);
        $display("got hits %0d miss %0d evict %0d totals %0d/%0d/%0d pad %h",
                 word[1:0], word[2], word[3], word[35:4], word[67:36],
                 word[99:68], word[103:100]);
      end
      mismatches++;
    end
  endfunction
endclass

module tb_set_assoc_lru_cache_sim;

  // mode three is not a named access kind; the block treats it as a load
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int PHASES          = 10;
  localparam int PHASE_WORDS     = 160;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int POOL_MAX        = 16;
  // tag shift once set and block bits sit at their clamp
  localparam int WIDE_SHIFT      = MAX_SET_BITS + MAX_BLOCK_BITS;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [4:0]   cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;   // [47:0] address
  logic [1:0]   in_tuser;   // [1:0] mode
  logic         out_tvalid;
  logic         out_tready;
  // [1:0] hits_added, [2] missed, [3] evicted, [35:4] total_hits,
  // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
  logic [103:0] out_tdata;

  cache_scoreboard sb;

  // calm drops all idling on both streams; hold_off_req asks the sink for
  // one long stall so the block backs up into its input
  bit calm;
  bit hold_off_req;
  int settings;

  // effective geometry, used only to shape generated addresses and the tag pool
  int cur_s, cur_b, cur_w;

  set_assoc_lru_cache_sim u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("set_assoc_lru_cache_sim verification failed");
    $finish;
  end

  // Offer one access word and hold it until the block takes it. Drop valid
  // only inside an idle burst, so back-to-back words keep valid high.
  task automatic send_access(input logic [1:0] mode, input logic [ADDR_BITS-1:0] addr);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      in_tdata  <= 48'({$urandom, $urandom});
      in_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    sb.note_access(mode, addr);
  endtask

  // Wait until every result is back, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Keep cfg_we high across the three writes; the caller lowers it.
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(input logic [2:0] s, input logic [4:0] b, input logic [3:0] w);
    drain();
    write_reg(CFG_SET_BITS, 5'(s));
    write_reg(CFG_BLOCK_BITS, b);
    write_reg(CFG_WAYS_USED, 5'(w));
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_s = (s > MAX_SET_BITS) ? MAX_SET_BITS : s;
    cur_b = (b > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : b;
    cur_w = (w == 0) ? 1 : ((w > WAYS) ? WAYS : w);
    settings++;
  endtask

  // Result sink: check each taken word, then pick next cycle's ready.
  initial begin : result_sink
    int stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_outcome(out_tdata);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [ADDR_BITS-1:0] tag_pool [POOL_MAX];
    logic [ADDR_BITS-1:0] tag, set_idx, offset, addr;
    int phase, n, roll, pool_live;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    settings     = 1;
    cur_s        = 4;
    cur_b        = 4;
    cur_w        = 1;
    sb           = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // Reset geometry, one way: cold miss, hit, far address, modify hit,
    // and the unnamed mode that must behave as a load.
    send_access(MODE_LOAD,   48'h0);
    send_access(MODE_LOAD,   48'h0);
    send_access(MODE_STORE,  48'hFFFF_FFFF_FFFF);
    send_access(MODE_MODIFY, 48'hFFFF_FFFF_FFFF);
    send_access(MODE_SPARE,  48'h0);

    // Oversized set and block bits clamp; two ways fill from the top, then
    // the oldest line goes out on each conflict.
    apply_config(3'd7, 5'd31, 4'd2);
    send_access(MODE_LOAD,   48'd1 << WIDE_SHIFT);
    send_access(MODE_LOAD,   48'd2 << WIDE_SHIFT);
    send_access(MODE_MODIFY, 48'd3 << WIDE_SHIFT);
    send_access(MODE_LOAD,   48'd1 << WIDE_SHIFT);
    send_access(MODE_STORE,  48'hFFFF_FFFF_FFFF);

    // Zero ways acts as one: refill way 0 with a tag that the parked way
    // still holds, then with a new tag. Then open all ways again: both lines
    // must hit, and stale ranks in the parked ways come back to life.
    apply_config(3'd7, 5'd31, 4'd0);
    send_access(MODE_LOAD,   48'd3 << WIDE_SHIFT);
    send_access(MODE_LOAD,   48'd5 << WIDE_SHIFT);
    apply_config(3'd7, 5'd31, 4'd15);
    send_access(MODE_LOAD,   48'd5 << WIDE_SHIFT);
    send_access(MODE_LOAD,   48'd3 << WIDE_SHIFT);
    send_access(MODE_LOAD,   48'd6 << WIDE_SHIFT);
    send_access(MODE_STORE,  48'd7 << WIDE_SHIFT);
    send_access(MODE_MODIFY, 48'd1 << WIDE_SHIFT);

    // One set, no offset: the whole address is the tag.
    apply_config(3'd0, 5'd0, 4'd3);
    for (n = 1; n <= 4; n++) send_access(MODE_LOAD, ADDR_BITS'(n));
    send_access(MODE_MODIFY, 48'd1);

    // --- random part ---
    // Each phase gets a geometry, the first few at the extremes, and a small
    // pool of tags so that most accesses land on few sets and hit often.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_config(3'd0, 5'd0,  4'd8);
        1: apply_config(3'd7, 5'd31, 4'd15);
        2: apply_config(3'd6, 5'd16, 4'd1);
        3: apply_config(3'd1, 5'd2,  4'd0);
        default: apply_config(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                              4'($urandom_range(0, 15)));
      endcase
      calm = (phase == PHASES - 1);
      if (phase == 4) hold_off_req = 1'b1;
      pool_live = cur_w + $urandom_range(1, 4);
      for (n = 0; n < POOL_MAX; n++)
        tag_pool[n] = (n % 2 == 0) ? ADDR_BITS'(n) : 48'({$urandom, $urandom});

      for (n = 0; n < PHASE_WORDS; n++) begin
        roll    = $urandom_range(0, 99);
        tag     = tag_pool[$urandom_range(0, pool_live - 1)];
        set_idx = ($urandom_range(0, 1) == 0) ? ADDR_BITS'($urandom_range(0, 1))
                                              : ADDR_BITS'($urandom);
        set_idx = set_idx & ~({ADDR_BITS{1'b1}} << cur_s);
        offset  = 48'({$urandom, $urandom}) & ~({ADDR_BITS{1'b1}} << cur_b);
        // mostly well-formed pool traffic, with some wild and extreme words
        if (roll < 10)
          addr = 48'({$urandom, $urandom});
        else if (roll < 12)
          addr = '1;
        else if (roll < 14)
          addr = '0;
        else
          addr = (tag << (cur_b + cur_s)) | (set_idx << cur_b) | offset;
        send_access(2'($urandom_range(0, 3)), addr);
      end
    end

    drain();
    $display("Covered %0d accesses across %0d register settings, with one long output stall.",
             sb.checked, settings);
    $display("Predicted totals: %0d hits, %0d misses, %0d evictions; %0d mismatches.",
             sb.hit_sum, sb.miss_sum, sb.evict_sum, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("set_assoc_lru_cache_sim verification clean");
    end else begin
      $display("set_assoc_lru_cache_sim verification failed");
    end
    $finish;
  end

endmodule
